>>> rtl/core/scg_pkg.sv
// scg_pkg: shared constants for the schoenberg curve point generator
// register indexes, field widths, reset values and parameter defaults
// no dependencies
`default_nettype none

package scg_pkg;

    // parameter defaults
    localparam int FRAC_BITS_DEF = 32;
    localparam int MAX_TERMS_DEF = 16;

    // field widths
    localparam int NUM_TERMS_W = 4;
    localparam int T_STEP_W    = 33;
    localparam int COORD_W     = 32;
    localparam int CFG_INDEX_W = 1;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_NUM_TERMS = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_T_STEP    = 1'd1;

    // configuration reset values
    localparam logic [NUM_TERMS_W-1:0] NUM_TERMS_RST = 4'd10;
    localparam logic [T_STEP_W-1:0]    T_STEP_RST    = 33'd4294967;

endpackage

`default_nettype wire

>>> rtl/core/scg_cell.sv
// scg_cell: one series term of the curve, one pipeline cell of the chain
// takes the reduced argument 9^k t mod 2 and the partial sums, adds term k,
// hands 9^(k+1) t mod 2 to the next cell; uses scg_pkg
`default_nettype none

module scg_cell #(
    parameter int FRAC_BITS = scg_pkg::FRAC_BITS_DEF,
    parameter int IDX       = 0
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic [scg_pkg::NUM_TERMS_W-1:0] num_terms,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [FRAC_BITS:0]              in_arg,
    input  wire logic [FRAC_BITS:0]              in_xsum,
    input  wire logic [FRAC_BITS:0]              in_ysum,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [FRAC_BITS:0]                   out_arg,
    output logic [FRAC_BITS:0]                   out_xsum,
    output logic [FRAC_BITS:0]                   out_ysum
);

    localparam int AW = FRAC_BITS + 1;
    localparam logic [AW+1:0] ONE_W = (AW+2)'(1) << FRAC_BITS;
    localparam logic [AW:0]   TWO   = (AW+1)'(1) << (FRAC_BITS + 1);
    localparam logic [AW-1:0] ONE   = AW'(1) << FRAC_BITS;

    // p(mirror(r)) with r already reduced mod 2
    function automatic logic [AW-1:0] base_fn(input logic [AW-1:0] r_in);
        logic [AW-1:0] r;
        logic [AW+1:0] v;
        logic [AW+1:0] w;
        logic [AW-1:0] res;
        r = r_in;
        if (r > ONE) begin
            r = AW'(TWO - {1'b0, r_in});
        end
        v = {2'b00, r} + {1'b0, r, 1'b0};
        w = v - ONE_W;
        if (v <= ONE_W) begin
            res = '0;
        end
        else if (w > ONE_W) begin
            res = ONE;
        end
        else begin
            res = AW'(w);
        end
        return res;
    endfunction

    logic          valid_reg;
    logic [AW-1:0] arg_reg;
    logic [AW-1:0] xsum_reg;
    logic [AW-1:0] ysum_reg;

    logic          term_en;
    logic [AW-1:0] arg3;
    logic [AW-1:0] arg9;
    logic [AW-1:0] xterm;
    logic [AW-1:0] yterm;
    logic [AW-1:0] xsum_next;
    logic [AW-1:0] ysum_next;

    // term k is summed only up to the configured last term
    assign term_en = (IDX <= int'(num_terms));

    // 3a and 9a modulo 2 by shift and add
    assign arg3 = in_arg + {in_arg[AW-2:0], 1'b0};
    assign arg9 = arg3 + {arg3[AW-2:0], 1'b0};

    // scaled terms, truncated by the shift
    assign xterm = base_fn(in_arg) >> (IDX + 1);
    assign yterm = base_fn(arg3) >> (IDX + 1);

    assign xsum_next = term_en ? (in_xsum + xterm) : in_xsum;
    assign ysum_next = term_en ? (in_ysum + yterm) : in_ysum;

    // cell takes a word when empty or when its word moves on
    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            arg_reg  <= arg9;
            xsum_reg <= xsum_next;
            ysum_reg <= ysum_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_arg   = arg_reg;
    assign out_xsum  = xsum_reg;
    assign out_ysum  = ysum_reg;

endmodule

`default_nettype wire

>>> rtl/core/schoenberg_curve_point_generator_unit.sv
// schoenberg_curve_point_generator_unit: top level of the curve point generator
// curve parameter register, configuration registers and a chain of scg_cell
// uses scg_pkg and scg_cell
//
// usage:
//   in channel (in_valid/in_ready, restart): each accepted word asks for one
//   point at the current parameter t; restart=1 sets t to zero first. t then
//   steps by t_step and saturates at 1.0, after which points repeat.
//   out channel (out_valid/out_ready, x_coord, y_coord): one word per input
//   word, in order, 32 fraction bits each.
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0 is
//   num_terms, index 1 is t_step; cfg_ready is always high.
//   chain: a word passes one cell of the chain per series term, and its result
//   sits in the output register, which is the register of the last cell.
//   throughput: one word per cycle while out_ready stays high; the chain of
//   MAX_TERMS cells holds up to MAX_TERMS words in flight.
//   stall: a word stays in the last cell while out_ready is low; earlier cells
//   keep filling empty slots, and in_ready drops once the chain is full.
//   reset: chain empty, t = 0, num_terms = 10, t_step = 4294967.
`default_nettype none

module schoenberg_curve_point_generator_unit #(
    parameter int FRAC_BITS = scg_pkg::FRAC_BITS_DEF,
    parameter int MAX_TERMS = scg_pkg::MAX_TERMS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // configuration
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [scg_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [scg_pkg::T_STEP_W-1:0]    cfg_data,
    // input words
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic                            restart,
    // output words
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [scg_pkg::COORD_W-1:0]          x_coord,
    output logic [scg_pkg::COORD_W-1:0]          y_coord
);

    localparam int AW = FRAC_BITS + 1;
    localparam logic [AW:0] ONE_W = (AW+1)'(1) << FRAC_BITS;

    logic [scg_pkg::NUM_TERMS_W-1:0] num_terms_reg;
    logic [scg_pkg::T_STEP_W-1:0]    t_step_reg;
    logic [AW-1:0]                   t_reg;
    logic [AW-1:0]                   t_next;

    logic [AW-1:0] t_used;
    logic [AW-1:0] step_fx;
    logic [AW:0]   t_sum;

    logic          c_valid [MAX_TERMS+1];
    logic          c_ready [MAX_TERMS+1];
    logic [AW-1:0] c_arg   [MAX_TERMS+1];
    logic [AW-1:0] c_xsum  [MAX_TERMS+1];
    logic [AW-1:0] c_ysum  [MAX_TERMS+1];

    // configuration write decode
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_terms_reg <= scg_pkg::NUM_TERMS_RST;
            t_step_reg    <= scg_pkg::T_STEP_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                scg_pkg::REG_NUM_TERMS:
                begin
                    num_terms_reg <= cfg_data[scg_pkg::NUM_TERMS_W-1:0];
                end
                scg_pkg::REG_T_STEP:
                begin
                    t_step_reg <= cfg_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    // step converted to the internal fraction width
    generate
        if (FRAC_BITS >= 32) begin : g_step_up
            assign step_fx = AW'(t_step_reg) << (FRAC_BITS - 32);
        end
        else begin : g_step_dn
            assign step_fx = AW'(t_step_reg >> (32 - FRAC_BITS));
        end
    endgenerate

    // parameter used by this word and its saturating advance
    assign t_used = restart ? '0 : t_reg;
    assign t_sum  = {1'b0, t_used} + {1'b0, step_fx};
    assign t_next = (t_sum > ONE_W) ? AW'(ONE_W) : AW'(t_sum);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_reg <= '0;
        end
        else if (in_valid && in_ready)
        begin
            t_reg <= t_next;
        end
    end

    // head of the chain
    assign c_valid[0] = in_valid;
    assign in_ready   = c_ready[0];
    assign c_arg[0]   = t_used;
    assign c_xsum[0]  = '0;
    assign c_ysum[0]  = '0;

    // one cell per series term
    generate
        for (genvar k = 0; k < MAX_TERMS; k++) begin : g_cell
            scg_cell #(
                .FRAC_BITS (FRAC_BITS),
                .IDX       (k)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .num_terms (num_terms_reg),
                .in_valid  (c_valid[k]),
                .in_ready  (c_ready[k]),
                .in_arg    (c_arg[k]),
                .in_xsum   (c_xsum[k]),
                .in_ysum   (c_ysum[k]),
                .out_valid (c_valid[k+1]),
                .out_ready (c_ready[k+1]),
                .out_arg   (c_arg[k+1]),
                .out_xsum  (c_xsum[k+1]),
                .out_ysum  (c_ysum[k+1])
            );
        end
    endgenerate

    // tail of the chain is the output register
    assign out_valid          = c_valid[MAX_TERMS];
    assign c_ready[MAX_TERMS] = out_ready;

    // sums to 32 fraction bits
    generate
        if (FRAC_BITS >= 32) begin : g_out_dn
            assign x_coord = scg_pkg::COORD_W'(c_xsum[MAX_TERMS] >> (FRAC_BITS - 32));
            assign y_coord = scg_pkg::COORD_W'(c_ysum[MAX_TERMS] >> (FRAC_BITS - 32));
        end
        else begin : g_out_up
            assign x_coord = scg_pkg::COORD_W'(33'(c_xsum[MAX_TERMS]) << (32 - FRAC_BITS));
            assign y_coord = scg_pkg::COORD_W'(33'(c_ysum[MAX_TERMS]) << (32 - FRAC_BITS));
        end
    endgenerate

endmodule

`default_nettype wire
